### hdl/qbf_pkg.sv
// ----------------------------------------------------------------------------
// qbf_pkg
// Shared types and fixed constants for the Bezier flattening unit.
// ----------------------------------------------------------------------------
package qbf_pkg;

  localparam int COLOR_W = 24;

  // Per-segment control that travels alongside the arithmetic
  typedef struct packed {
    logic               first;
    logic               last;
    logic [COLOR_W-1:0] color;
  } qbf_side_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } qbf_state_t;

endpackage

### hdl/qbf_seq.sv
// ----------------------------------------------------------------------------
// qbf_seq
// Takes one curve request, works out the segment count and issues k = 1..n.
// ----------------------------------------------------------------------------
module qbf_seq
  import qbf_pkg::*;
#(
  parameter int MIN_SEGMENTS = 20,
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_WIDTH  = 16,
  parameter int KW           = 7
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] ctrl_x,
  input  logic signed [COORD_WIDTH-1:0] ctrl_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic [COLOR_W-1:0]            color,
  input  logic                          en,
  output logic                          iss_valid,
  output logic [KW-1:0]                 iss_k,
  output logic [KW-1:0]                 iss_n,
  output logic signed [COORD_WIDTH-1:0] pts [6],
  output qbf_side_t                     iss_side
);
  localparam int CW = COORD_WIDTH;

  qbf_state_t               state;
  logic [KW-1:0]            k;
  logic [KW-1:0]            n;
  logic [COLOR_W-1:0]       col;
  logic signed [CW+1:0]     dx, dy;
  logic [CW+1:0]            ax, ay;
  logic [CW+3:0]            curv1;
  logic [KW-1:0]            n_next;
  logic                     accept;

  always_comb begin
    dx = (CW+2)'(start_x) - ((CW+2)'(ctrl_x) <<< 1) + (CW+2)'(end_x);
    dy = (CW+2)'(start_y) - ((CW+2)'(ctrl_y) <<< 1) + (CW+2)'(end_y);
    ax = dx[CW+1] ? (CW+2)'(-dx) : dx;
    ay = dy[CW+1] ? (CW+2)'(-dy) : dy;
    curv1 = (CW+4)'(ax) + (CW+4)'(ay) + (CW+4)'(1);
    if (curv1 < (CW+4)'(MIN_SEGMENTS)) begin
      n_next = KW'(MIN_SEGMENTS);
    end else if (curv1 > (CW+4)'(MAX_SEGMENTS)) begin
      n_next = KW'(MAX_SEGMENTS);
    end else begin
      n_next = curv1[KW-1:0];
    end
  end

  // a new curve only lands on an advancing edge, so the numerator stage
  // still sees the old points for the last issued k
  assign in_stall  = (state != ST_IDLE) || !en;
  assign accept    = in_valid && !in_stall;
  assign iss_valid = (state == ST_RUN);
  assign iss_k     = k;
  assign iss_n     = n;
  assign iss_side  = '{first: (k == KW'(1)), last: (k == n), color: col};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_RUN;
            k     <= KW'(1);
          end
        end
        ST_RUN: begin
          if (en) begin
            k <= k + KW'(1);
            if (k == n) state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      n      <= n_next;
      col    <= color;
      pts[0] <= start_x;
      pts[1] <= start_y;
      pts[2] <= ctrl_x;
      pts[3] <= ctrl_y;
      pts[4] <= end_x;
      pts[5] <= end_y;
    end
  end
endmodule

### hdl/qbf_weights.sv
// ----------------------------------------------------------------------------
// qbf_weights
// Bernstein weights (n-k)^2, 2k(n-k), k^2 and the divisor n^2, one stage.
// ----------------------------------------------------------------------------
module qbf_weights #(
  parameter int KW = 7
) (
  input  logic            clk,
  input  logic            en,
  input  logic [KW-1:0]   k,
  input  logic [KW-1:0]   n,
  output logic [2*KW-1:0] rr,
  output logic [2*KW-1:0] kr2,
  output logic [2*KW-1:0] kk,
  output logic [2*KW-1:0] nn
);
  logic [KW-1:0] r;
  assign r = n - k;

  always_ff @(posedge clk) begin
    if (en) begin
      rr  <= (2*KW)'(r) * (2*KW)'(r);
      kr2 <= ((2*KW)'(k) * (2*KW)'(r)) << 1;
      kk  <= (2*KW)'(k) * (2*KW)'(k);
      nn  <= (2*KW)'(n) * (2*KW)'(n);
    end
  end
endmodule

### hdl/qbf_numer.sv
// ----------------------------------------------------------------------------
// qbf_numer
// One axis: weighted sum of the three points, then magnitude and rounding
// offset for the divider. Two stages.
// ----------------------------------------------------------------------------
module qbf_numer #(
  parameter int KW = 7,
  parameter int CW = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*KW-1:0]       rr,
  input  logic [2*KW-1:0]       kr2,
  input  logic [2*KW-1:0]       kk,
  input  logic [2*KW-1:0]       nn,
  input  logic signed [CW-1:0]  a,
  input  logic signed [CW-1:0]  b,
  input  logic signed [CW-1:0]  c,
  output logic [2*KW+CW:0]      dividend,
  output logic [2*KW+CW:0]      divisor,
  output logic                  neg
);
  localparam int PW = 2*KW+CW+1;

  logic signed [PW-1:0] pa, pb, pc;
  logic [2*KW-1:0]      nn_d;
  logic signed [PW-1:0] sum;
  logic [PW-1:0]        mag;

  always_ff @(posedge clk) begin
    if (en) begin
      pa   <= $signed({1'b0, rr})  * PW'(a);
      pb   <= $signed({1'b0, kr2}) * PW'(b);
      pc   <= $signed({1'b0, kk})  * PW'(c);
      nn_d <= nn;
    end
  end

  always_comb begin
    sum = pa + pb + pc;
    mag = sum[PW-1] ? PW'(-sum) : PW'(sum);
  end

  // round half away from zero: (2|num| + n^2) / (2 n^2)
  always_ff @(posedge clk) begin
    if (en) begin
      dividend <= (mag << 1) + PW'(nn_d);
      divisor  <= PW'(nn_d) << 1;
      neg      <= sum[PW-1];
    end
  end
endmodule

### hdl/qbf_div.sv
// ----------------------------------------------------------------------------
// qbf_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qbf_div #(
  parameter int WW = 39,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [WW-1:0] dividend,
  input  logic [WW-1:0] divisor,
  input  logic          neg_in,
  output logic [QW-1:0] quo,
  output logic          neg_out
);
  localparam int XW = WW + QW;

  logic [WW-1:0] rem [QW+1];
  logic [WW-1:0] dv  [QW+1];
  logic [QW-1:0] q   [QW+1];
  logic          sg  [QW+1];

  assign rem[0] = dividend;
  assign dv[0]  = divisor;
  assign q[0]   = '0;
  assign sg[0]  = neg_in;

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [XW-1:0] shv;
    logic          ge;
    assign shv = XW'(dv[s]) << B;
    assign ge  = XW'(rem[s]) >= shv;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= ge ? WW'(XW'(rem[s]) - shv) : rem[s];
        dv[s+1]  <= dv[s];
        q[s+1]   <= q[s] | (ge ? (QW'(1) << B) : QW'(0));
        sg[s+1]  <= sg[s];
      end
    end
  end

  assign quo     = q[QW];
  assign neg_out = sg[QW];
endmodule

### hdl/quad_bezier_uniform_flatten_unit.sv
// ----------------------------------------------------------------------------
// quad_bezier_uniform_flatten_unit
// Flattens quadratic Bezier curves into n uniform-step line segments.
// ----------------------------------------------------------------------------
// Path: sequencer, weights, numerator and divider stages, then the output register.
// Throughput: one segment per cycle unless the output is stalled; a curve of n
// (MIN..MAX) segments also costs the k sequencer its accepting cycle, and it holds
// off the next request until its last issue and while the output is stalled.
// Reset (rst, synchronous) clears the sequencer and all pipeline valid bits.
module quad_bezier_uniform_flatten_unit
  import qbf_pkg::*;
#(
  parameter int MIN_SEGMENTS = 20,
  parameter int MAX_SEGMENTS = 64,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] start_x,
  input  logic signed [COORD_WIDTH-1:0] start_y,
  input  logic signed [COORD_WIDTH-1:0] ctrl_x,
  input  logic signed [COORD_WIDTH-1:0] ctrl_y,
  input  logic signed [COORD_WIDTH-1:0] end_x,
  input  logic signed [COORD_WIDTH-1:0] end_y,
  input  logic [COLOR_W-1:0]            color,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_WIDTH-1:0] from_x,
  output logic signed [COORD_WIDTH-1:0] from_y,
  output logic signed [COORD_WIDTH-1:0] to_x,
  output logic signed [COORD_WIDTH-1:0] to_y,
  output logic [COLOR_W-1:0]            seg_color,
  output logic                          last
);
  localparam int CW  = COORD_WIDTH;
  localparam int KW  = $clog2(MAX_SEGMENTS + 1);
  localparam int WW  = 2*KW + CW + 1;
  // weights 1 + numerator 2 + divider CW stages
  localparam int LAT = CW + 3;

  // whole pipe advances unless the output register holds an unaccepted segment
  logic en;
  assign en = !(out_valid && out_stall);

  logic                 iss_valid;
  logic [KW-1:0]        iss_k, iss_n;
  logic signed [CW-1:0] pts [6];
  qbf_side_t            iss_side;

  qbf_seq #(
    .MIN_SEGMENTS(MIN_SEGMENTS), .MAX_SEGMENTS(MAX_SEGMENTS),
    .COORD_WIDTH(CW), .KW(KW)
  ) u_seq (
    .clk, .rst, .in_valid, .in_stall,
    .start_x, .start_y, .ctrl_x, .ctrl_y, .end_x, .end_y, .color,
    .en, .iss_valid, .iss_k, .iss_n, .pts, .iss_side
  );

  logic [2*KW-1:0] rr, kr2, kk, nn;

  qbf_weights #(.KW(KW)) u_weights (
    .clk, .en, .k(iss_k), .n(iss_n), .rr, .kr2, .kk, .nn
  );

  // control points held until the last weights have entered the numerator
  logic [WW-1:0] dnd_x, dsr_x, dnd_y, dsr_y;
  logic          neg_x, neg_y;

  qbf_numer #(.KW(KW), .CW(CW)) u_numer_x (
    .clk, .en, .rr, .kr2, .kk, .nn,
    .a(pts[0]), .b(pts[2]), .c(pts[4]),
    .dividend(dnd_x), .divisor(dsr_x), .neg(neg_x)
  );

  qbf_numer #(.KW(KW), .CW(CW)) u_numer_y (
    .clk, .en, .rr, .kr2, .kk, .nn,
    .a(pts[1]), .b(pts[3]), .c(pts[5]),
    .dividend(dnd_y), .divisor(dsr_y), .neg(neg_y)
  );

  logic [CW-1:0] q_x, q_y;
  logic          sx, sy;

  qbf_div #(.WW(WW), .QW(CW)) u_div_x (
    .clk, .en, .dividend(dnd_x), .divisor(dsr_x), .neg_in(neg_x),
    .quo(q_x), .neg_out(sx)
  );

  qbf_div #(.WW(WW), .QW(CW)) u_div_y (
    .clk, .en, .dividend(dnd_y), .divisor(dsr_y), .neg_in(neg_y),
    .quo(q_y), .neg_out(sy)
  );

  // sideband line: valid, first/last/colour and the start point
  logic                 v_line  [LAT+1];
  qbf_side_t            sd_line [LAT+1];
  logic signed [CW-1:0] sx_line [LAT+1];
  logic signed [CW-1:0] sy_line [LAT+1];

  assign v_line[0]  = iss_valid;
  assign sd_line[0] = iss_side;
  assign sx_line[0] = pts[0];
  assign sy_line[0] = pts[1];

  for (genvar i = 0; i < LAT; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        v_line[i+1] <= 1'b0;
      end else if (en) begin
        v_line[i+1] <= v_line[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sd_line[i+1] <= sd_line[i];
        sx_line[i+1] <= sx_line[i];
        sy_line[i+1] <= sy_line[i];
      end
    end
  end

  // apply sign; magnitude never exceeds half range so negation fits
  logic signed [CW-1:0] px, py;
  assign px = sx ? CW'(-q_x) : CW'(q_x);
  assign py = sy ? CW'(-q_y) : CW'(q_y);

  // output register; from-point is the previous segment's end, or the start
  qbf_side_t sd_o;
  assign sd_o = sd_line[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_line[LAT];
    end
  end

  always_ff @(posedge clk) begin
    if (en && v_line[LAT]) begin
      from_x    <= sd_o.first ? sx_line[LAT] : to_x;
      from_y    <= sd_o.first ? sy_line[LAT] : to_y;
      to_x      <= px;
      to_y      <= py;
      seg_color <= sd_o.color;
      last      <= sd_o.last;
    end
  end
endmodule

### sim/quad_bezier_uniform_flatten_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quad_bezier_uniform_flatten_unit_tb
// Self-checking bench: curve requests are driven from a queue. Each accepted
// curve is expanded into its expected segments by an integer predictor, and
// every segment leaving the unit is compared with the oldest one waiting.
// ----------------------------------------------------------------------------
module quad_bezier_uniform_flatten_unit_tb;
  import qbf_pkg::*;

  localparam int MIN_SEG  = 20;
  localparam int MAX_SEG  = 64;
  localparam int CW       = 16;
  localparam int N_RANDOM = 440;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic signed [CW-1:0] sx, sy, cx, cy, ex, ey;
    logic [COLOR_W-1:0]   col;
  } curve_t;

  typedef struct packed {
    logic signed [CW-1:0] fx, fy, tx, ty;
    logic [COLOR_W-1:0]   col;
    logic                 lst;
  } segment_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CW-1:0] start_x = '0, start_y = '0, ctrl_x = '0, ctrl_y = '0;
  logic signed [CW-1:0] end_x = '0, end_y = '0;
  logic [COLOR_W-1:0] color = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CW-1:0] from_x, from_y, to_x, to_y;
  logic [COLOR_W-1:0] seg_color;
  logic last;

  curve_t   pending_curves[$];
  segment_t expected_segs[$];
  int       mismatches = 0;
  longint   cycles = 0;
  int       src_idle_pct = 0;  // chance the sender skips a cycle
  int       snk_stall_pct = 0; // chance the receiver stalls
  bit       hold_off = 1'b0;   // sender holds back new requests
  bit       driving = 1'b0;
  bit       in_acc = 1'b0;     // request taken at the last rising edge

  always #5 clk = ~clk;

  quad_bezier_uniform_flatten_unit #(
    .MIN_SEGMENTS(MIN_SEG), .MAX_SEGMENTS(MAX_SEG), .COORD_WIDTH(CW)
  ) u_dut (.*);

  // Bezier point at k/n, rounded to nearest with ties away from zero
  function automatic logic signed [CW-1:0] bez_point(longint a, longint b, longint c,
                                                     longint k, longint n);
    longint r, num, den, q;
    r = n - k;
    num = r * r * a + 2 * k * r * b + k * k * c;
    den = n * n;
    if (num >= 0) q = (2 * num + den) / (2 * den);
    else q = -((2 * (-num) + den) / (2 * den));
    return q[CW-1:0];
  endfunction

  // Expand one accepted curve into its segment list
  task automatic flatten_curve(curve_t c);
    longint d2x, d2y, n;
    segment_t s;
    logic signed [CW-1:0] px, py, qx, qy;
    d2x = longint'(c.sx) - 2 * longint'(c.cx) + longint'(c.ex);
    d2y = longint'(c.sy) - 2 * longint'(c.cy) + longint'(c.ey);
    if (d2x < 0) d2x = -d2x;
    if (d2y < 0) d2y = -d2y;
    n = d2x + d2y + 1;
    if (n < MIN_SEG) n = MIN_SEG;
    if (n > MAX_SEG) n = MAX_SEG;
    px = c.sx;
    py = c.sy;
    for (longint k = 1; k <= n; k++) begin
      qx = bez_point(c.sx, c.cx, c.ex, k, n);
      qy = bez_point(c.sy, c.cy, c.ey, k, n);
      s = '{fx: px, fy: py, tx: qx, ty: qy, col: c.col, lst: (k == n)};
      expected_segs.push_back(s);
      px = qx;
      py = qy;
    end
  endtask

  // Handshake seen at the rising edge, used by the driver at the falling edge
  always @(posedge clk) begin
    in_acc <= !rst && in_valid && !in_stall;
  end

  // Driver: the payload is updated at the falling edge, held while stalled
  always @(negedge clk) begin
    if (!rst) begin
      if (in_acc) begin
        flatten_curve(pending_curves.pop_front());
      end
      if (!in_valid || in_acc) begin
        if (pending_curves.size() != 0 && !hold_off &&
            $urandom_range(99) >= src_idle_pct) begin
          in_valid <= 1'b1;
          {start_x, start_y, ctrl_x, ctrl_y, end_x, end_y, color} <= pending_curves[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < snk_stall_pct);
    end
  end

  // Monitor: sample segments at the rising edge
  always @(posedge clk) begin
    segment_t got, want;
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      got = '{fx: from_x, fy: from_y, tx: to_x, ty: to_y, col: seg_color, lst: last};
      if (expected_segs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected segment %p", got);
      end else begin
        want = expected_segs.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("segment mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  // Note: the predictor runs at the negedge after acceptance, so the drain
  // check also waits until the driver's queue has been accepted.
  task automatic wait_drained();
    while (pending_curves.size() != 0 || in_valid || expected_segs.size() != 0)
      @(posedge clk);
    repeat (CW + 20) @(posedge clk);
  endtask

  function automatic logic signed [CW-1:0] rnd_coord();
    case ($urandom_range(5))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return CW'($urandom_range(40) - 20);
      default: return CW'($urandom());
    endcase
  endfunction

  task automatic add_curve(int sx, int sy, int cx, int cy, int ex, int ey, int col);
    pending_curves.push_back('{sx: CW'(sx), sy: CW'(sy), cx: CW'(cx), cy: CW'(cy),
                               ex: CW'(ex), ey: CW'(ey), col: COLOR_W'(col)});
  endtask

  task automatic add_random(int count);
    int base_x, base_y, span;
    repeat (count) begin
      if ($urandom_range(1)) begin
        // small curvature to cover every n between the clamps
        base_x = $urandom_range(60000) - 30000;
        base_y = $urandom_range(60000) - 30000;
        span = $urandom_range(40);
        add_curve(base_x, base_y, base_x + $urandom_range(span) - span / 2,
                  base_y + $urandom_range(span) - span / 2,
                  base_x + $urandom_range(2 * span) - span,
                  base_y + $urandom_range(2 * span) - span, $urandom());
      end else begin
        add_curve(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_coord(), rnd_coord(), $urandom());
      end
    end
  endtask

  // Timeout watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("quad_bezier_uniform_flatten_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: straight line, degenerate, extremes, saturating curvature
    add_curve(0, 0, 0, 0, 0, 0, 0);
    add_curve(-100, -100, 0, 0, 100, 100, 24'hffffff);
    add_curve(-32768, -32768, -32768, -32768, -32768, -32768, 24'h123456);
    add_curve(32767, 32767, 32767, 32767, 32767, 32767, 24'h800001);
    add_curve(-32768, -32768, 32767, 32767, -32768, -32768, 24'haaaaaa);
    add_curve(32767, -32768, -32768, 32767, 32767, -32768, 24'h555555);
    add_curve(-32768, 32767, 32767, -32768, 32767, 32767, 24'h0f0f0f);
    add_curve(0, 0, 5, 0, 0, 0, 24'h000001);   // curvature 10, clamps to min
    add_curve(0, 0, 10, 0, 0, 0, 24'h000002);  // curvature 20, n = 21
    add_curve(0, 0, 31, 0, 0, 1, 24'h000003);  // n = 64
    add_curve(0, 0, 32, 0, 0, 0, 24'h000004);  // just over max
    add_curve(1, -1, 0, 0, -1, 1, 24'hf0f0f0);
    add_curve(-7, 3, 9, -12, 4, 4, 24'h00ff00);

    src_idle_pct = 29;
    snk_stall_pct = 82;
    add_random(150);
    wait_drained();

    // Sender held back after everything has drained, then let go
    hold_off = 1'b1;
    add_random(5);
    repeat (30) @(posedge clk);
    hold_off = 1'b0;

    src_idle_pct = 82;
    snk_stall_pct = 29;
    add_random(150);
    wait_drained();

    src_idle_pct = 0;
    snk_stall_pct = 0;
    add_random(N_RANDOM - 300);
    wait_drained();

    if (mismatches == 0 && expected_segs.size() == 0) begin
      $display("quad_bezier_uniform_flatten_unit_tb OK");
    end else begin
      $display("quad_bezier_uniform_flatten_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
